[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent implies consequent on the following edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// types and codes shared by the page translation table modules
// ----------------------------------------------------------------------------
package ptt_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [19:0] virtual_page;
        logic [15:0] physical_page;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] found_page;
        logic [6:0]  occupancy;
    } rsp_t;

    // one table slot as held in the memory
    typedef struct packed {
        logic        valid;
        logic [19:0] key;
        logic [15:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // outcome of one scan over the table
    typedef struct packed {
        logic        hit;
        logic        free_found;
        logic [15:0] hit_page;
    } match_t;

endpackage

[sv/ptt_ram.sv]
// ----------------------------------------------------------------------------
// ptt_ram
// generic single-clock ram, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/ptt_match.sv]
// ----------------------------------------------------------------------------
// ptt_match
// compares each slot read during a scan against the key and keeps the first
// matching slot and the lowest free slot
// ----------------------------------------------------------------------------
module ptt_match #(
    parameter int ENTRIES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       rd_vld,
    input  logic [$clog2(ENTRIES)-1:0] rd_idx,
    input  ptt_pkg::entry_t            rd_entry,
    input  logic [19:0]                key,
    output ptt_pkg::match_t            info,
    output logic [$clog2(ENTRIES)-1:0] hit_idx,
    output logic [$clog2(ENTRIES)-1:0] free_idx
);

    localparam int AW = $clog2(ENTRIES);

    logic          hit_reg, hit_next;
    logic          free_reg, free_next;
    logic [15:0]   page_reg, page_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;

    always_comb
    begin
        hit_next      = hit_reg;
        free_next     = free_reg;
        page_next     = page_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        priority if (clear)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (rd_vld)
        begin
            if (rd_entry.valid && (rd_entry.key == key) && !hit_reg)
            begin
                hit_next     = 1'b1;
                page_next    = rd_entry.value;
                hit_idx_next = rd_idx;
            end
            if (!rd_entry.valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = rd_idx;
            end
        end
        else
        begin
            // nothing read this cycle: hold
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign info.hit        = hit_reg;
    assign info.free_found = free_reg;
    assign info.hit_page   = page_reg;
    assign hit_idx         = hit_idx_reg;
    assign free_idx        = free_idx_reg;

endmodule

[sv/page_translation_table.sv]
// ----------------------------------------------------------------------------
// page_translation_table
// bounded table mapping virtual page numbers to physical page numbers
// ----------------------------------------------------------------------------
// A command transfers on a rising edge with start high and busy low. The cmd
// struct carries opcode (insert, search, delete), virtual_page as the key and
// physical_page for insert. Exactly one result follows per command: done is
// high for one cycle with the result struct (status, found, found_page and
// occupancy after the operation); the receiver cannot stall it.
// Each command scans every slot of one memory port, one slot a cycle, then
// drains the read pipeline (S_DRAIN) and updates the table (S_EXEC).
// busy falls in the same cycle that done rises, so a new command may
// transfer then; no new command is taken while one is in progress.
// After reset the memory is swept clear, one slot a cycle, with busy high;
// no command is taken until the sweep ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_translation_table #(
    parameter int ENTRIES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ptt_pkg::req_t  cmd,
    output logic           done,
    output ptt_pkg::rsp_t  result
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EXEC  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [CW-1:0]   count_reg, count_next;
    ptt_pkg::req_t   cmd_reg, cmd_next;
    logic            done_reg, done_next;
    ptt_pkg::rsp_t   rsp_reg, rsp_next;
    logic            rd_vld_reg;
    logic [AW-1:0]   rd_idx_reg;

    logic            we, re, clear;
    logic [AW-1:0]   waddr;
    ptt_pkg::entry_t wentry;
    logic [ptt_pkg::ENTRY_W-1:0] rdata;
    ptt_pkg::entry_t rd_entry;
    ptt_pkg::match_t info;
    logic [AW-1:0]   hit_idx, free_idx;
    logic            last;
    logic [CW+6:0]   occ_ext;

    ptt_ram #(
        .WIDTH (ptt_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .re    (re),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign rd_entry = ptt_pkg::entry_t'(rdata);

    ptt_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clear),
        .rd_vld   (rd_vld_reg),
        .rd_idx   (rd_idx_reg),
        .rd_entry (rd_entry),
        .key      (cmd_reg.virtual_page),
        .info     (info),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    assign last    = (addr_reg == AW'(ENTRIES - 1));
    assign occ_ext = {7'd0, count_next};

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        we         = 1'b0;
        re         = 1'b0;
        clear      = 1'b0;
        waddr      = addr_reg;
        wentry     = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we        = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (last)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    addr_next  = '0;
                    clear      = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                re        = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (last)
                begin
                    addr_next  = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read data is being taken by the match unit
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                rsp_next.status     = ptt_pkg::ST_OK;
                rsp_next.found      = 1'b0;
                rsp_next.found_page = '0;
                unique case (cmd_reg.opcode)
                    ptt_pkg::OP_INSERT:
                    begin
                        priority if (info.hit)
                        begin
                            rsp_next.status = ptt_pkg::ST_DUP;
                        end
                        else if (!info.free_found)
                        begin
                            rsp_next.status = ptt_pkg::ST_FULL;
                        end
                        else
                        begin
                            we           = 1'b1;
                            waddr        = free_idx;
                            wentry.valid = 1'b1;
                            wentry.key   = cmd_reg.virtual_page;
                            wentry.value = cmd_reg.physical_page;
                            count_next   = count_reg + CW'(1);
                        end
                    end
                    ptt_pkg::OP_SEARCH:
                    begin
                        if (info.hit)
                        begin
                            rsp_next.found      = 1'b1;
                            rsp_next.found_page = info.hit_page;
                        end
                        else
                        begin
                            rsp_next.status = ptt_pkg::ST_MISS;
                        end
                    end
                    ptt_pkg::OP_DELETE:
                    begin
                        if (info.hit)
                        begin
                            // valid cleared, rest of the slot is don't care
                            we    = 1'b1;
                            waddr = hit_idx;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        else
                        begin
                            rsp_next.status = ptt_pkg::ST_MISS;
                        end
                    end
                    default:
                    begin
                        // unused opcode: no change
                    end
                endcase
                rsp_next.occupancy = occ_ext[6:0];
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            rd_vld_reg <= re;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rsp_reg    <= rsp_next;
        rd_idx_reg <= addr_reg;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    `ASSERT_CLK(a_done_after_exec,
                !done_reg || ($past(state_reg) == S_EXEC),
                "result without update step")
    `ASSERT_CLK(a_count_bound, count_reg <= CW'(ENTRIES), "occupancy above capacity")
    `ASSERT_CLK(a_found_ok,
                !(done_reg && rsp_reg.found) || (rsp_reg.status == ptt_pkg::ST_OK),
                "found with bad status")
    `ASSERT_NEXT(a_start_scans, start && !busy, state_reg == S_SCAN,
                 "accepted command did not start a scan")

endmodule
